### sv/lis_pkg.sv
// Shared types and constants for the longest-increasing-subsequence core.
// Used by lis_tail_ram and lis_min_deletions_core; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package lis_pkg;

  localparam int KEY_W  = 32;  // width of a biased tail key
  localparam int DEL_W  = 10;  // width of the deletions result field
  localparam int LEN_W  = 11;  // width of the lis_length result field

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_FINISH
  } lis_state_t;

  // Flip the sign bit so an unsigned compare orders values as signed.
  function automatic logic [KEY_W-1:0] to_key(input logic signed [KEY_W-1:0] v);
    to_key = {~v[KEY_W-1], v[KEY_W-2:0]};
  endfunction

endpackage

`default_nettype wire

### sv/lis_min_deletions_core.sv
// Top level: streaming LIS length / minimum-deletions core (patience sort).
// Depends on lis_pkg and lis_tail_ram.
//
//   channel | direction | ports                                   | handshake
//   --------+-----------+-----------------------------------------+-------------
//   in      | input     | in_value[31:0] signed, in_last          | valid/stall
//   out     | output    | out_deletions[9:0], out_lis_length[10:0],| valid/stall
//           |           | out_overflow                            |
//
// An item enters in the idle state, then probes the tails RAM in a binary
// search (one read per cycle): up to ceil(log2(run_length+1)) probes. An
// item flagged last then passes the finish state, which loads the result
// register. Items past MAX_ITEMS only set the overflow flag. Reset is
// synchronous and clears the state, counters and flags; the RAM is never
// cleared since only entries below run_length are read. A stalled result
// waits in the output register; the next item may enter meanwhile, and only
// a second last item waits in the finish state until the register frees up.
`timescale 1ns / 1ps
`default_nettype none

module lis_min_deletions_core
  import lis_pkg::*;
#(
  parameter int MAX_ITEMS = 1024
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic signed [KEY_W-1:0] in_value,
  input  wire logic                    in_last,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic             [DEL_W-1:0] out_deletions,
  output logic             [LEN_W-1:0] out_lis_length,
  output logic                         out_overflow
);

  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int EW = (CW > LEN_W) ? CW : LEN_W;

  lis_state_t state_r, state_nxt;

  logic [CW-1:0]    run_length_r, run_length_nxt;
  logic [CW-1:0]    item_count_r, item_count_nxt;
  logic             overflow_seen_r, overflow_seen_nxt;
  logic [CW-1:0]    lo_r, lo_nxt;
  logic [CW-1:0]    hi_r, hi_nxt;
  logic [CW-1:0]    mid_r, mid_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic             last_r, last_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [DEL_W-1:0] out_deletions_r, out_deletions_nxt;
  logic [LEN_W-1:0] out_lis_length_r, out_lis_length_nxt;
  logic             out_overflow_r, out_overflow_nxt;

  logic             in_accept;
  logic             out_free;
  logic             full_now;
  logic [KEY_W-1:0] key_in;

  // one probe step of the binary search
  logic             tail_below;
  logic [CW-1:0]    lo_step, hi_step, mid_step;
  logic             search_more;
  logic [EW-1:0]    del_ext;

  logic             ram_wr_en, ram_rd_en;
  logic [AW-1:0]    ram_wr_addr, ram_rd_addr;
  logic [KEY_W-1:0] ram_wr_data, ram_rd_data;

  lis_tail_ram #(
    .DEPTH (MAX_ITEMS),
    .AW    (AW)
  ) u_tails (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign full_now  = (item_count_r == CW'(MAX_ITEMS));
  assign key_in    = to_key(in_value);

  always_comb begin
    tail_below  = (ram_rd_data < key_r);
    lo_step     = tail_below ? (mid_r + CW'(1)) : lo_r;
    hi_step     = tail_below ? hi_r : mid_r;
    mid_step    = lo_step + ((hi_step - lo_step) >> 1);
    search_more = (lo_step < hi_step);
    del_ext     = EW'(item_count_r) - EW'(run_length_r);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          if (!full_now && (run_length_r != '0)) begin
            state_nxt = ST_PROBE;
          end else if (in_last) begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_PROBE: begin
        if (!search_more) begin
          state_nxt = last_r ? ST_FINISH : ST_IDLE;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and RAM controls
  always_comb begin
    run_length_nxt     = run_length_r;
    item_count_nxt     = item_count_r;
    overflow_seen_nxt  = overflow_seen_r;
    lo_nxt             = lo_r;
    hi_nxt             = hi_r;
    mid_nxt            = mid_r;
    key_nxt            = key_r;
    last_nxt           = last_r;
    out_valid_nxt      = out_valid_r && out_stall;
    out_deletions_nxt  = out_deletions_r;
    out_lis_length_nxt = out_lis_length_r;
    out_overflow_nxt   = out_overflow_r;
    ram_wr_en          = 1'b0;
    ram_wr_addr        = '0;
    ram_wr_data        = key_r;
    ram_rd_en          = 1'b0;
    ram_rd_addr        = mid_r[AW-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          key_nxt  = key_in;
          last_nxt = in_last;
          if (full_now) begin
            overflow_seen_nxt = 1'b1;
          end else if (run_length_r == '0) begin
            // empty store: append at once
            ram_wr_en      = 1'b1;
            ram_wr_addr    = '0;
            ram_wr_data    = key_in;
            run_length_nxt = CW'(1);
            item_count_nxt = item_count_r + CW'(1);
          end else begin
            lo_nxt      = '0;
            hi_nxt      = run_length_r;
            mid_nxt     = run_length_r >> 1;
            ram_rd_en   = 1'b1;
            ram_rd_addr = mid_nxt[AW-1:0];
          end
        end
      end
      ST_PROBE: begin
        lo_nxt = lo_step;
        hi_nxt = hi_step;
        if (search_more) begin
          mid_nxt     = mid_step;
          ram_rd_en   = 1'b1;
          ram_rd_addr = mid_step[AW-1:0];
        end else begin
          // replace the first tail not below the key, or append
          ram_wr_en      = 1'b1;
          ram_wr_addr    = lo_step[AW-1:0];
          item_count_nxt = item_count_r + CW'(1);
          if (lo_step == run_length_r) begin
            run_length_nxt = run_length_r + CW'(1);
          end
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt      = 1'b1;
          out_deletions_nxt  = del_ext[DEL_W-1:0];
          out_lis_length_nxt = LEN_W'(run_length_r);
          out_overflow_nxt   = overflow_seen_r;
          run_length_nxt     = '0;
          item_count_nxt     = '0;
          overflow_seen_nxt  = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      run_length_r    <= '0;
      item_count_r    <= '0;
      overflow_seen_r <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      run_length_r    <= run_length_nxt;
      item_count_r    <= item_count_nxt;
      overflow_seen_r <= overflow_seen_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r             <= lo_nxt;
    hi_r             <= hi_nxt;
    mid_r            <= mid_nxt;
    key_r            <= key_nxt;
    last_r           <= last_nxt;
    out_deletions_r  <= out_deletions_nxt;
    out_lis_length_r <= out_lis_length_nxt;
    out_overflow_r   <= out_overflow_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_deletions  = out_deletions_r;
  assign out_lis_length = out_lis_length_r;
  assign out_overflow   = out_overflow_r;

  // a tail exists for at most every counted item
  a_len_le_count: assert property (@(posedge clk) disable iff (!rst_n)
    run_length_r <= item_count_r)
    else $error("run_length exceeds item_count");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    item_count_r <= CW'(MAX_ITEMS))
    else $error("item_count beyond MAX_ITEMS");

  // search window stays non-empty and inside the stored tails while probing
  a_probe_window: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_PROBE |-> (lo_r <= mid_r) && (mid_r < hi_r) && (hi_r <= run_length_r))
    else $error("binary search window out of range");

  // loading a result clears the sequence counters
  a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH) && out_free |=> (run_length_r == '0) && (item_count_r == '0)
      && out_valid_r && !overflow_seen_r)
    else $error("sequence state not cleared after result");

  // never write and read the RAM in the same cycle
  a_ram_one_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_wr_en && ram_rd_en))
    else $error("RAM read and write collide");

endmodule

`default_nettype wire

### sv/lis_tail_ram.sv
// Tails store: single-port-write, single-port-read synchronous RAM.
// Read data is registered. Depends on lis_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lis_tail_ram
  import lis_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [AW-1:0]     wr_addr,
  input  wire logic [KEY_W-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [AW-1:0]     rd_addr,
  output logic      [KEY_W-1:0]  rd_data
);

  logic [KEY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### verif/lis_min_deletions_core_tb.sv
// Self-checking testbench for lis_min_deletions_core (patience-sort LIS length and deletions).
// Depends on lis_pkg and the core; drives items from a queue and checks results against
// an in-bench tails-store predictor.
`timescale 1ns / 1ps

module lis_min_deletions_core_tb;
  import lis_pkg::*;

  localparam int LIS_DEPTH   = 1024;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 40;

  typedef struct {
    logic signed [KEY_W-1:0] value;
    logic                    last;
  } stim_item_t;

  typedef struct {
    logic [DEL_W-1:0] deletions;
    logic [LEN_W-1:0] lis_length;
    logic             overflow;
  } lis_result_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic signed [KEY_W-1:0] in_value = '0;
  logic                    in_last = 1'b0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic        [DEL_W-1:0] out_deletions;
  logic        [LEN_W-1:0] out_lis_length;
  logic                    out_overflow;

  stim_item_t  stim_q[$];
  lis_result_t lis_expect_q[$];

  // predictor state
  logic [KEY_W-1:0] tail_keys [LIS_DEPTH];
  int               run_len = 0;
  int               seq_items = 0;
  logic             seq_overflow = 1'b0;

  int err_cnt = 0;
  int cycle_cnt = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;

  always #1 clk = ~clk;

  lis_min_deletions_core #(
    .MAX_ITEMS(LIS_DEPTH)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_value      (in_value),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_deletions (out_deletions),
    .out_lis_length(out_lis_length),
    .out_overflow  (out_overflow)
  );

  // Place one accepted value into the tails store; emit a result on last.
  function automatic void lis_predict(input logic signed [KEY_W-1:0] value, input logic last);
    logic [KEY_W-1:0] key;
    int               lo;
    int               hi;
    int               mid;
    lis_result_t      res;
    key = value ^ 32'h8000_0000;
    if (seq_items >= LIS_DEPTH) begin
      seq_overflow = 1'b1;
    end else begin
      lo = 0;
      hi = run_len;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (tail_keys[mid] < key) lo = mid + 1;
        else hi = mid;
      end
      if (lo < LIS_DEPTH) begin
        tail_keys[lo] = key;
        if (lo == run_len) run_len++;
      end
      seq_items++;
    end
    if (last) begin
      res.deletions  = DEL_W'(seq_items - run_len);
      res.lis_length = LEN_W'(run_len);
      res.overflow   = seq_overflow;
      lis_expect_q.insert(lis_expect_q.size(), res);
      run_len      = 0;
      seq_items    = 0;
      seq_overflow = 1'b0;
    end
  endfunction

  // driver
  always @(posedge clk) begin
    stim_item_t item;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) lis_predict(in_value, in_last);
      if (!in_valid || !in_stall) begin
        if (stim_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          item = stim_q.pop_front();
          in_valid <= 1'b1;
          in_value <= item.value;
          in_last  <= item.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, counted here
  always @(posedge clk) begin
    if (hold_ack != hold_req) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    lis_result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (lis_expect_q.size() == 0) begin
          err_cnt <= err_cnt + 1;
          $display("%0t: unexpected result del=%0d len=%0d ovf=%0d", $time,
                   out_deletions, out_lis_length, out_overflow);
        end else begin
          want = lis_expect_q.pop_front();
          if (out_deletions !== want.deletions || out_lis_length !== want.lis_length ||
              out_overflow !== want.overflow) begin
            err_cnt <= err_cnt + 1;
            if (out_deletions !== want.deletions)
              $display("%0t: deletions expected %0d got %0d", $time,
                       want.deletions, out_deletions);
            if (out_lis_length !== want.lis_length)
              $display("%0t: lis_length expected %0d got %0d", $time,
                       want.lis_length, out_lis_length);
            if (out_overflow !== want.overflow)
              $display("%0t: overflow expected %0d got %0d", $time,
                       want.overflow, out_overflow);
          end
        end
      end
      out_stall <= (hold_left > 0) || ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic push_item(input logic signed [KEY_W-1:0] value, input logic last);
    stim_item_t item;
    item.value = value;
    item.last  = last;
    stim_q.insert(stim_q.size(), item);
  endtask

  task automatic wait_drained();
    while (stim_q.size() != 0 || in_valid || lis_expect_q.size() != 0) @(negedge clk);
  endtask

  function automatic logic signed [KEY_W-1:0] pick_extreme();
    case ($urandom_range(0, 6))
      0: pick_extreme = 32'sh8000_0000;
      1: pick_extreme = 32'sh8000_0001;
      2: pick_extreme = -32'sd1;
      3: pick_extreme = 32'sd0;
      4: pick_extreme = 32'sd1;
      5: pick_extreme = 32'sh7FFF_FFFE;
      default: pick_extreme = 32'sh7FFF_FFFF;
    endcase
  endfunction

  // Queue whole sequences with random content until about n items are queued.
  task automatic queue_random(input int n);
    int queued;
    int len;
    int mode;
    int cur;
    logic signed [KEY_W-1:0] v;
    queued = 0;
    while (queued < n) begin
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 80) : $urandom_range(1, 12);
      mode = $urandom_range(0, 4);
      cur  = $urandom_range(0, 2000) - 1000;
      for (int i = 0; i < len; i++) begin
        case (mode)
          0: v = $urandom;
          1: v = $urandom_range(0, 8) - 4;
          2: begin
            cur = cur + $urandom_range(0, 5) - 1;
            v   = cur;
          end
          3: begin
            cur = cur - $urandom_range(0, 5) + 1;
            v   = cur;
          end
          default: v = pick_extreme();
        endcase
        push_item(v, i == len - 1);
      end
      queued += len;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: single items, extremes, sign boundary, duplicates, append and replace
    push_item(32'sd0, 1'b1);
    push_item(32'sh8000_0000, 1'b1);
    push_item(32'sh7FFF_FFFF, 1'b1);
    push_item(32'sh8000_0000, 1'b0);
    push_item(32'sh7FFF_FFFF, 1'b1);
    push_item(32'sh7FFF_FFFF, 1'b0);
    push_item(32'sh8000_0000, 1'b1);
    push_item(32'sd5, 1'b0);
    push_item(32'sd5, 1'b0);
    push_item(32'sd5, 1'b1);
    push_item(-32'sd1, 1'b0);
    push_item(32'sd0, 1'b0);
    push_item(32'sd1, 1'b1);
    push_item(32'sd3, 1'b0);
    push_item(32'sd1, 1'b0);
    push_item(32'sd2, 1'b0);
    push_item(32'sd4, 1'b0);
    push_item(32'sd0, 1'b1);
    push_item(32'sh5555_5555, 1'b0);
    push_item(32'shAAAA_AAAA, 1'b0);
    push_item(32'sh5555_5555, 1'b0);
    push_item(-32'sd2, 1'b1);
    wait_drained();

    // full store: strictly increasing, then ignored items with the last one flagged
    for (int i = 0; i < LIS_DEPTH + 3; i++) begin
      if (i < LIS_DEPTH) push_item(i * 3000000 - 1500000000, 1'b0);
      else push_item(32'sh8000_0000, i == LIS_DEPTH + 2);
    end
    wait_drained();

    queue_random(25);
    wait_drained();

    send_idle_pct  = 46;
    recv_stall_pct = 0;
    queue_random(25);
    wait_drained();

    send_idle_pct  = 0;
    recv_stall_pct = 46;
    queue_random(25);
    wait_drained();

    send_idle_pct  = 28;
    recv_stall_pct = 28;
    queue_random(25);
    wait_drained();

    // hold the result side while short sequences keep arriving, so input backs up
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = hold_req + 1;
    for (int s = 0; s < 20; s++) begin
      for (int i = 0; i < 2; i++) push_item($urandom, i == 1);
    end
    wait_drained();

    send_idle_pct  = 28;
    recv_stall_pct = 28;
    queue_random(20);
    wait_drained();

    repeat (SETTLE) @(negedge clk);
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
